[rtl/cookie_header_parser_top_assert.svh]
// Assertion macros used by the checker file.
`ifndef COOKIE_HEADER_PARSER_TOP_ASSERT_SVH
`define COOKIE_HEADER_PARSER_TOP_ASSERT_SVH

// Same-cycle implication, masked during reset.
`define CHP_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, masked during reset.
`define CHP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/chp_pkg.sv]
// ----------------------------------------------------------------------------
// chp_pkg
// Types, character codes and keyword tables for the cookie header parser.
// ----------------------------------------------------------------------------
package chp_pkg;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       end_of_header;
  } chp_in_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] byte_value_res;
    logic [1:0] name_class;
    logic       closes_previous;
    logic       header_ok;
  } chp_out_t;

  localparam logic [2:0] KIND_NAME     = 3'd0;
  localparam logic [2:0] KIND_VALUE    = 3'd1;
  localparam logic [2:0] KIND_PATH     = 3'd2;
  localparam logic [2:0] KIND_DOMAIN   = 3'd3;
  localparam logic [2:0] KIND_NAME_END = 3'd4;
  localparam logic [2:0] KIND_FINISH   = 3'd5;

  localparam logic [1:0] CLASS_PLAIN   = 2'd0;
  localparam logic [1:0] CLASS_VERSION = 2'd1;
  localparam logic [1:0] CLASS_PATH    = 2'd2;
  localparam logic [1:0] CLASS_DOMAIN  = 2'd3;

  localparam logic [1:0] VCHK_NONE  = 2'd0;
  localparam logic [1:0] VCHK_ONE   = 2'd1;
  localparam logic [1:0] VCHK_OTHER = 2'd2;

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] TOKEN_LO = 8'd32;
  localparam logic [7:0] TOKEN_HI = 8'd126;

  localparam logic [3:0] NAME_POS_MAX = 4'd15;

  // Keywords: $Version, $Path, $Domain
  localparam logic [7:0] KW_TEXT [0:2][0:7] = '{
    '{8'h24, 8'h56, 8'h65, 8'h72, 8'h73, 8'h69, 8'h6F, 8'h6E},
    '{8'h24, 8'h50, 8'h61, 8'h74, 8'h68, 8'h00, 8'h00, 8'h00},
    '{8'h24, 8'h44, 8'h6F, 8'h6D, 8'h61, 8'h69, 8'h6E, 8'h00}
  };
  localparam logic [3:0] KW_LEN [0:2] = '{4'd8, 4'd5, 4'd7};

  function automatic logic is_blank(logic [7:0] b);
    return (b == CH_SP) || (b == CH_TAB);
  endfunction

  function automatic logic is_token(logic [7:0] b);
    logic sep;
    case (b)
      8'h28, 8'h29, 8'h3C, 8'h3E, 8'h40, 8'h2C, 8'h3B, 8'h3A, 8'h5C,
      8'h22, 8'h2F, 8'h5B, 8'h5D, 8'h3F, 8'h3D, 8'h7B, 8'h7D: sep = 1'b1;
      default: sep = 1'b0;
    endcase
    return (b >= TOKEN_LO) && (b <= TOKEN_HI) && !sep;
  endfunction

endpackage

[rtl/chp_engine.sv]
// ----------------------------------------------------------------------------
// chp_engine
// Parser state and per-beat step logic; result is combinational.
// ----------------------------------------------------------------------------
module chp_engine
  import chp_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     beat_en,
  input  chp_in_t  beat_in,
  output logic     res_vld,
  output chp_out_t res
);

  typedef enum logic [2:0] {
    PH_PRE_NAME, PH_NAME, PH_POST_NAME, PH_PRE_DATA,
    PH_DATA, PH_QUOTED, PH_POST_DATA, PH_DEAD
  } phase_t;

  phase_t     phase_r, phase_nxt;
  logic       first_pair_r, first_pair_nxt;
  logic       adv_r, adv_nxt;
  logic [1:0] vclass_r, vclass_nxt;
  logic       open_r, open_nxt;
  logic [3:0] pos_r, pos_nxt;
  logic [2:0] hits_r, hits_nxt;
  logic [1:0] vchk_r, vchk_nxt;

  logic [7:0] b;
  logic       sep_end;
  logic [2:0] nb_hits;
  logic [3:0] nb_pos;
  logic [1:0] ne_cls;
  logic       close_ok;
  logic       fin_ok;

  assign b = beat_in.byte_value;
  assign sep_end = (b == CH_SEMI) || ((b == CH_COMMA) && first_pair_r);
  assign close_ok = (vclass_r != CLASS_VERSION) || (vchk_r == VCHK_ONE);
  assign nb_pos = (pos_r == NAME_POS_MAX) ? pos_r : pos_r + 4'd1;

  always_comb begin
    nb_hits = hits_r;
    for (int k = 0; k < 3; k++) begin
      if ((pos_r >= KW_LEN[k[1:0]]) || (KW_TEXT[k[1:0]][pos_r[2:0]] != b)) begin
        nb_hits[k] = 1'b0;
      end
    end
  end

  always_comb begin
    ne_cls = CLASS_PLAIN;
    if (first_pair_r && hits_r[0] && (pos_r == KW_LEN[0])) begin
      ne_cls = CLASS_VERSION;
    end else if (adv_r) begin
      if (hits_r[1] && (pos_r == KW_LEN[1])) begin
        ne_cls = CLASS_PATH;
      end else if (hits_r[2] && (pos_r == KW_LEN[2])) begin
        ne_cls = CLASS_DOMAIN;
      end
    end
  end

  always_comb begin
    phase_nxt      = phase_r;
    first_pair_nxt = first_pair_r;
    adv_nxt        = adv_r;
    vclass_nxt     = vclass_r;
    open_nxt       = open_r;
    pos_nxt        = pos_r;
    hits_nxt       = hits_r;
    vchk_nxt       = vchk_r;
    res_vld        = 1'b0;
    res            = '0;
    fin_ok         = 1'b0;

    if (beat_in.end_of_header) begin
      if (phase_r == PH_DATA) begin
        fin_ok = open_r && close_ok;
      end else if (phase_r == PH_POST_DATA) begin
        fin_ok = 1'b1;
      end
      res_vld             = 1'b1;
      res.kind            = KIND_FINISH;
      res.closes_previous = fin_ok && open_r;
      res.header_ok       = fin_ok;
      phase_nxt      = PH_PRE_NAME;
      first_pair_nxt = 1'b1;
      adv_nxt        = 1'b0;
      vclass_nxt     = CLASS_PLAIN;
      open_nxt       = 1'b0;
      pos_nxt        = '0;
      hits_nxt       = 3'b111;
      vchk_nxt       = VCHK_NONE;
    end else begin
      unique case (phase_r)
        PH_PRE_NAME, PH_NAME: begin
          if ((phase_r == PH_NAME) && ((b == CH_EQ) || is_blank(b))) begin
            phase_nxt = (b == CH_EQ) ? PH_PRE_DATA : PH_POST_NAME;
            res_vld         = 1'b1;
            res.kind        = KIND_NAME_END;
            res.name_class  = ne_cls;
            if (ne_cls == CLASS_PLAIN) begin
              res.closes_previous = open_r;
              open_nxt            = 1'b1;
            end
            vclass_nxt = ne_cls;
            vchk_nxt   = VCHK_NONE;
            pos_nxt    = '0;
            hits_nxt   = 3'b111;
          end else if ((phase_r == PH_PRE_NAME) && is_blank(b)) begin
            phase_nxt = phase_r;
          end else if (is_token(b)) begin
            phase_nxt          = PH_NAME;
            hits_nxt           = nb_hits;
            pos_nxt            = nb_pos;
            res_vld            = 1'b1;
            res.kind           = KIND_NAME;
            res.byte_value_res = b;
          end else begin
            phase_nxt = PH_DEAD;
          end
        end
        PH_POST_NAME: begin
          if (b == CH_EQ) begin
            phase_nxt = PH_PRE_DATA;
          end else if (!is_blank(b)) begin
            phase_nxt = PH_DEAD;
          end
        end
        PH_PRE_DATA, PH_DATA, PH_QUOTED: begin
          priority if ((phase_r == PH_PRE_DATA) && (b == CH_QUOTE)) begin
            phase_nxt = PH_QUOTED;
          end else if ((phase_r == PH_PRE_DATA) && is_blank(b)) begin
            phase_nxt = phase_r;
          end else if ((phase_r == PH_DATA) && (sep_end || is_blank(b))) begin
            if (sep_end) begin
              first_pair_nxt = 1'b0;
            end
            if (close_ok) begin
              phase_nxt = sep_end ? PH_PRE_NAME : PH_POST_DATA;
              if (vclass_r == CLASS_VERSION) begin
                adv_nxt = 1'b1;
              end
            end else begin
              phase_nxt = PH_DEAD;
            end
          end else if ((phase_r == PH_QUOTED) && (b == CH_QUOTE)) begin
            if (close_ok) begin
              phase_nxt = PH_POST_DATA;
              if (vclass_r == CLASS_VERSION) begin
                adv_nxt = 1'b1;
              end
            end else begin
              phase_nxt = PH_DEAD;
            end
          end else if ((phase_r == PH_QUOTED) || is_token(b)) begin
            if (phase_r == PH_PRE_DATA) begin
              phase_nxt = PH_DATA;
            end
            if (vclass_r == CLASS_VERSION) begin
              vchk_nxt = ((vchk_r == VCHK_NONE) && (b == CH_ONE)) ? VCHK_ONE : VCHK_OTHER;
            end else begin
              res_vld            = 1'b1;
              res.kind           = (vclass_r == CLASS_PLAIN) ? KIND_VALUE : {1'b0, vclass_r};
              res.byte_value_res = b;
            end
          end else begin
            phase_nxt = PH_DEAD;
          end
        end
        PH_POST_DATA: begin
          if (sep_end) begin
            first_pair_nxt = 1'b0;
            phase_nxt      = PH_PRE_NAME;
          end else if (!is_blank(b)) begin
            phase_nxt = PH_DEAD;
          end
        end
        PH_DEAD: begin
          phase_nxt = PH_DEAD;
        end
        default: begin
          phase_nxt = PH_DEAD;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_PRE_NAME;
      first_pair_r <= 1'b1;
      adv_r        <= 1'b0;
      vclass_r     <= CLASS_PLAIN;
      open_r       <= 1'b0;
      pos_r        <= '0;
      hits_r       <= 3'b111;
      vchk_r       <= VCHK_NONE;
    end else if (beat_en) begin
      phase_r      <= phase_nxt;
      first_pair_r <= first_pair_nxt;
      adv_r        <= adv_nxt;
      vclass_r     <= vclass_nxt;
      open_r       <= open_nxt;
      pos_r        <= pos_nxt;
      hits_r       <= hits_nxt;
      vchk_r       <= vchk_nxt;
    end
  end

endmodule

[rtl/cookie_header_parser_top.sv]
// ----------------------------------------------------------------------------
// cookie_header_parser_top
// Cookie header parser: one header byte per beat in, tagged byte/event out.
//
//   channel | ports                       | payload
//   in      | in_valid, in_stall, in_data | chp_in_t  (byte, end flag)
//   out     | out_valid, out_stall, out_data | chp_out_t (kind, byte, class, flags)
//
// One beat per cycle while in_stall is low; a result lands in the output register
// in the cycle after its input beat is taken. Bytes that give no result leave the
// output empty. in_stall is raised only while the output register holds a result
// and out_stall is high. Synchronous reset returns the parser to "before name".
// ----------------------------------------------------------------------------
module cookie_header_parser_top
  import chp_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  chp_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output chp_out_t out_data
);

  logic     take;
  logic     res_vld;
  chp_out_t res;
  logic     out_valid_r;
  chp_out_t out_data_r;

  assign in_stall = out_valid_r && out_stall;
  assign take     = in_valid && !in_stall;

  chp_engine u_engine (
    .clk     (clk),
    .rst_n   (rst_n),
    .beat_en (take),
    .beat_in (in_data),
    .res_vld (res_vld),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take) begin
      out_valid_r <= res_vld;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[rtl/chp_checker.sv]
// ----------------------------------------------------------------------------
// chp_checker
// Port-level checks for the cookie header parser, bound to the top level.
// ----------------------------------------------------------------------------
`include "cookie_header_parser_top_assert.svh"

module chp_checker
  import chp_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     in_valid,
  input logic     in_stall,
  input chp_in_t  in_data,
  input logic     out_valid,
  input logic     out_stall,
  input chp_out_t out_data
);

  logic out_held;
  logic take_end;
  logic fin_beat;
  logic evt_beat;
  logic zero_byte;

  assign out_held  = out_valid && out_stall;
  assign take_end  = in_valid && !in_stall && in_data.end_of_header;
  assign fin_beat  = out_valid && (out_data.kind == KIND_FINISH);
  assign evt_beat  = out_valid && (out_data.kind == KIND_NAME_END);
  assign zero_byte = (out_data.byte_value_res == 8'd0);

  `CHP_ASSERT_NEXT(a_out_hold, out_held, out_valid && $stable(out_data), "held beat changed")
  `CHP_ASSERT_NEXT(a_finish_follows, take_end, fin_beat, "header end gave no finish beat")
  `CHP_ASSERT_IMPLY(a_kind_range, out_valid, out_data.kind <= KIND_FINISH, "kind out of range")
  `CHP_ASSERT_IMPLY(a_ok_only_finish, out_valid && !fin_beat, !out_data.header_ok, "stray ok")
  `CHP_ASSERT_IMPLY(a_event_no_byte, evt_beat || fin_beat, zero_byte, "event beat has a byte")

endmodule

bind cookie_header_parser_top chp_checker u_chp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

[sim/cookie_header_parser_top_tb.sv]
// ----------------------------------------------------------------------------
// cookie_header_parser_top_tb
// Self-checking bench for the cookie header parser.
//
// A short table of hand-picked beats comes first: byte extremes in a quoted
// value, a comma after the first pair, a dead parser, a $Version pair and
// error finishes. Random headers follow. Most are well-formed cookie lists
// with keywords, quoted and token values, blanks and long names, and a few
// are noise. Every accepted beat goes through a local model of the parser.
// Each result taken from the block is compared field by field with the
// oldest expected one. Both sides idle at random, and the receiver holds off
// twice for a long stretch so that the input side backs up.
// ----------------------------------------------------------------------------
module cookie_header_parser_top_tb
  import chp_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 400_000;
  localparam int ITEM_TARGET = 1600;
  localparam int DIR_ROWS    = 26;

  localparam logic [7:0] C_TAB   = 8'h09;
  localparam logic [7:0] C_SP    = 8'h20;
  localparam logic [7:0] C_QUOTE = 8'h22;
  localparam logic [7:0] C_DOLLAR = 8'h24;
  localparam logic [7:0] C_COMMA = 8'h2C;
  localparam logic [7:0] C_ONE   = 8'h31;
  localparam logic [7:0] C_SEMI  = 8'h3B;
  localparam logic [7:0] C_EQ    = 8'h3D;

  localparam int KW_VERSION = 0;
  localparam int KW_PATH    = 1;
  localparam int KW_DOMAIN  = 2;

  localparam int SIDE_SEND = 0;
  localparam int SIDE_RECV = 1;

  localparam chp_out_t NO_RESULT = '0;

  typedef enum logic [2:0] {
    ST_PRE_NAME, ST_NAME, ST_POST_NAME, ST_PRE_VAL,
    ST_VAL, ST_QUOTED, ST_POST_VAL, ST_DEAD
  } parse_st_t;

  typedef struct packed {
    chp_in_t  item;
    logic     typed;
    chp_out_t want;
  } beat_row_t;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  chp_in_t  in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  chp_out_t out_data;

  cookie_header_parser_top DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  beat_row_t beat_q[$];
  chp_out_t  result_q[$];
  beat_row_t directed_tbl [DIR_ROWS];

  int  errors = 0;
  int  cycles = 0;
  int  taken_beats = 0;
  bit  in_took = 1'b0;
  bit  hold_off = 1'b0;
  int  calm_left [2];
  int  send_gap = 0;
  int  stall_run = 0;

  // parser model state
  parse_st_t  st;
  logic       at_first_pair;
  logic       long_form;
  logic [1:0] val_class;
  logic       cookie_live;
  logic [3:0] name_pos;
  logic [2:0] kw_alive;
  logic [1:0] ver_seen;

  // ---------------------------------------------------------------- model
  function automatic void parser_clear();
    st            = ST_PRE_NAME;
    at_first_pair = 1'b1;
    long_form     = 1'b0;
    val_class     = CLASS_PLAIN;
    cookie_live   = 1'b0;
    name_pos      = '0;
    kw_alive      = 3'b111;
    ver_seen      = VCHK_NONE;
  endfunction

  function automatic bit blank_char(logic [7:0] b);
    return (b == C_SP) || (b == C_TAB);
  endfunction

  function automatic bit tok_char(logic [7:0] b);
    string seps;
    int    i;
    seps = "()<>@,;:\\\"/[]?={}";
    if (b < 8'd32 || b > 8'd126) return 1'b0;
    for (i = 0; i < seps.len(); i++)
      if (seps[i] == b) return 1'b0;
    return 1'b1;
  endfunction

  function automatic string kw_word(int k);
    case (k)
      KW_VERSION: return "$Version";
      KW_PATH:    return "$Path";
      default:    return "$Domain";
    endcase
  endfunction

  function automatic bit kw_full(int k);
    string w;
    w = kw_word(k);
    return kw_alive[k] && (name_pos == w.len());
  endfunction

  function automatic void take_name_byte(input logic [7:0] b, output chp_out_t res);
    string w;
    int    k;
    for (k = 0; k < 3; k++) begin
      w = kw_word(k);
      if (!(name_pos < w.len() && w[name_pos] == b)) kw_alive[k] = 1'b0;
    end
    if (name_pos != 4'd15) name_pos = name_pos + 4'd1;
    res = '0;
    res.kind = KIND_NAME;
    res.byte_value_res = b;
  endfunction

  function automatic void close_name(output chp_out_t res);
    logic [1:0] cls;
    cls = CLASS_PLAIN;
    res = '0;
    if (at_first_pair && kw_full(KW_VERSION)) begin
      cls = CLASS_VERSION;
    end else if (long_form) begin
      if (kw_full(KW_PATH)) cls = CLASS_PATH;
      else if (kw_full(KW_DOMAIN)) cls = CLASS_DOMAIN;
    end
    if (cls == CLASS_PLAIN) begin
      res.closes_previous = cookie_live;
      cookie_live = 1'b1;
    end
    val_class = cls;
    ver_seen  = VCHK_NONE;
    name_pos  = '0;
    kw_alive  = 3'b111;
    res.kind = KIND_NAME_END;
    res.name_class = cls;
  endfunction

  function automatic bit take_value_byte(input logic [7:0] b, output chp_out_t res);
    res = '0;
    if (val_class == CLASS_VERSION) begin
      if (ver_seen == VCHK_NONE && b == C_ONE) ver_seen = VCHK_ONE;
      else ver_seen = VCHK_OTHER;
      return 1'b0;
    end
    res.byte_value_res = b;
    case (val_class)
      CLASS_PATH:   res.kind = KIND_PATH;
      CLASS_DOMAIN: res.kind = KIND_DOMAIN;
      default:      res.kind = KIND_VALUE;
    endcase
    return 1'b1;
  endfunction

  // a $Version value must be exactly "1"; it enables $Path/$Domain
  function automatic bit value_closes();
    if (val_class == CLASS_VERSION) begin
      if (ver_seen != VCHK_ONE) return 1'b0;
      long_form = 1'b1;
    end
    return 1'b1;
  endfunction

  function automatic bit cookie_step(input chp_in_t it, output chp_out_t res);
    logic [7:0] b;
    bit         ends_pair;
    bit         ok;
    b = it.byte_value;
    res = '0;
    ok = 1'b0;
    if (it.end_of_header) begin
      if (st == ST_VAL) ok = cookie_live && value_closes();
      else if (st == ST_POST_VAL) ok = 1'b1;
      res.kind = KIND_FINISH;
      res.closes_previous = ok && cookie_live;
      res.header_ok = ok;
      parser_clear();
      return 1'b1;
    end
    ends_pair = (b == C_SEMI) || (b == C_COMMA && at_first_pair);
    case (st)
      ST_PRE_NAME: begin
        if (blank_char(b)) return 1'b0;
        if (tok_char(b)) begin
          st = ST_NAME;
          take_name_byte(b, res);
          return 1'b1;
        end
      end
      ST_NAME: begin
        if (b == C_EQ) begin
          st = ST_PRE_VAL;
          close_name(res);
          return 1'b1;
        end
        if (blank_char(b)) begin
          st = ST_POST_NAME;
          close_name(res);
          return 1'b1;
        end
        if (tok_char(b)) begin
          take_name_byte(b, res);
          return 1'b1;
        end
      end
      ST_POST_NAME: begin
        if (b == C_EQ) begin
          st = ST_PRE_VAL;
          return 1'b0;
        end
        if (blank_char(b)) return 1'b0;
      end
      ST_PRE_VAL: begin
        if (b == C_QUOTE) begin
          st = ST_QUOTED;
          return 1'b0;
        end
        if (blank_char(b)) return 1'b0;
        if (tok_char(b)) begin
          st = ST_VAL;
          return take_value_byte(b, res);
        end
      end
      ST_VAL: begin
        if (ends_pair) begin
          at_first_pair = 1'b0;
          if (value_closes()) begin
            st = ST_PRE_NAME;
            return 1'b0;
          end
        end else if (blank_char(b)) begin
          if (value_closes()) begin
            st = ST_POST_VAL;
            return 1'b0;
          end
        end else if (tok_char(b)) begin
          return take_value_byte(b, res);
        end
      end
      ST_QUOTED: begin
        if (b != C_QUOTE) return take_value_byte(b, res);
        if (value_closes()) begin
          st = ST_POST_VAL;
          return 1'b0;
        end
      end
      ST_POST_VAL: begin
        if (ends_pair) begin
          at_first_pair = 1'b0;
          st = ST_PRE_NAME;
          return 1'b0;
        end
        if (blank_char(b)) return 1'b0;
      end
      default: return 1'b0;
    endcase
    st = ST_DEAD;
    return 1'b0;
  endfunction

  // ------------------------------------------------------------ stimulus
  task automatic push_row(input logic [7:0] b, input logic eoh);
    beat_row_t r;
    r.item.byte_value = b;
    r.item.end_of_header = eoh;
    r.typed = 1'b0;
    r.want = NO_RESULT;
    beat_q.push_back(r);
  endtask

  // rare stray byte ahead of the intended one
  task automatic push_byte(input logic [7:0] b);
    if ($urandom_range(0, 149) == 0) push_row(8'($urandom_range(0, 255)), 1'b0);
    push_row(b, 1'b0);
  endtask

  task automatic push_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) push_byte(s[i]);
  endtask

  task automatic push_blanks();
    int n;
    n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
    repeat (n) push_byte($urandom_range(0, 1) ? C_SP : C_TAB);
  endtask

  task automatic push_tokens(input int n);
    logic [7:0] b;
    repeat (n) begin
      do b = 8'($urandom_range(32, 126)); while (!tok_char(b));
      push_byte(b);
    end
  endtask

  task automatic push_sep();
    push_byte(($urandom_range(0, 2) == 0) ? C_COMMA : C_SEMI);
  endtask

  task automatic push_name();
    case ($urandom_range(0, 11))
      0, 1: push_text("$Path");
      2, 3: push_text("$Domain");
      4:    push_text("$Version");
      5:    push_text("$Pat");
      6:    push_text("$Domains");
      7: begin
        push_byte(C_DOLLAR);
        push_tokens($urandom_range(8, 20));
      end
      default: begin
        if ($urandom_range(0, 4) == 0) push_byte(C_DOLLAR);
        push_tokens($urandom_range(1, 6));
      end
    endcase
  endtask

  task automatic push_value();
    logic [7:0] b;
    int         n;
    if ($urandom_range(0, 3) == 0) begin
      push_byte(C_QUOTE);
      n = $urandom_range(0, 6);
      repeat (n) begin
        do b = 8'($urandom_range(0, 255)); while (b == C_QUOTE);
        push_byte(b);
      end
      push_byte(C_QUOTE);
    end else begin
      push_tokens(($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 6));
    end
  endtask

  task automatic gen_header();
    int i;
    int pairs;
    if ($urandom_range(0, 99) < 6) begin
      repeat ($urandom_range(1, 10)) push_row(8'($urandom_range(0, 255)), 1'b0);
    end else begin
      if ($urandom_range(0, 99) < 45) begin
        push_blanks();
        push_text("$Version");
        push_blanks();
        push_byte(C_EQ);
        push_blanks();
        case ($urandom_range(0, 9))
          0: ;
          1: push_text("2");
          2: push_text("11");
          3: begin
            push_byte(C_QUOTE);
            push_byte(C_ONE);
            push_byte(C_QUOTE);
          end
          4: begin
            push_byte(C_QUOTE);
            push_byte(C_QUOTE);
          end
          default: push_byte(C_ONE);
        endcase
        push_blanks();
        push_sep();
      end
      pairs = $urandom_range(1, 4);
      for (i = 0; i < pairs; i++) begin
        push_blanks();
        push_name();
        push_blanks();
        push_byte(C_EQ);
        push_blanks();
        push_value();
        push_blanks();
        if (i < pairs - 1) push_sep();
      end
      case ($urandom_range(0, 9))
        0: push_sep();
        1: begin
          push_sep();
          push_name();
        end
        default: ;
      endcase
    end
    push_row(8'($urandom_range(0, 255)), 1'b1);
  endtask

  // mostly short gaps, a few long ones, and calm stretches with none
  function automatic int idle_len(input int side);
    int r;
    if (calm_left[side] > 0) begin
      calm_left[side]--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) calm_left[side] = $urandom_range(20, 60);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  // ------------------------------------------------------------ checking
  task automatic report_mismatch(input string what, input int got, input int want);
    $display("ERROR @%0t: %s got %0d expected %0d", $time, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin : monitor
    beat_row_t row;
    chp_out_t  guess;
    chp_out_t  w;
    bit        hit;
    in_took = 1'b0;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (result_q.size() == 0) begin
          report_mismatch("result with none pending, kind", out_data.kind, 0);
        end else begin
          w = result_q.pop_front();
          if (out_data.kind != w.kind)
            report_mismatch("kind", out_data.kind, w.kind);
          if (out_data.byte_value_res != w.byte_value_res)
            report_mismatch("byte_value_res", out_data.byte_value_res, w.byte_value_res);
          if (out_data.name_class != w.name_class)
            report_mismatch("name_class", out_data.name_class, w.name_class);
          if (out_data.closes_previous != w.closes_previous)
            report_mismatch("closes_previous", out_data.closes_previous, w.closes_previous);
          if (out_data.header_ok != w.header_ok)
            report_mismatch("header_ok", out_data.header_ok, w.header_ok);
        end
      end
      if (in_valid && !in_stall) begin
        in_took = 1'b1;
        taken_beats++;
        row = beat_q.pop_front();
        hit = cookie_step(in_data, guess);
        if (row.typed) result_q.push_back(row.want);
        else if (hit) result_q.push_back(guess);
      end
    end
  end

  // ------------------------------------------------------------- drivers
  always @(negedge clk) begin : sender
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_took) begin
      if (send_gap > 0 && !hold_off) begin
        in_valid <= 1'b0;
        send_gap--;
      end else if (beat_q.size() > 0) begin
        in_valid <= 1'b1;
        in_data  <= beat_q[0].item;
        send_gap = idle_len(SIDE_SEND);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin : receiver
    if (hold_off || stall_run > 0) begin
      out_stall <= 1'b1;
      if (stall_run > 0) stall_run--;
    end else begin
      out_stall <= 1'b0;
      stall_run = idle_len(SIDE_RECV);
    end
  end

  // long hold-offs on the result side while beats keep coming
  initial begin : backpressure
    wait (taken_beats >= 300);
    @(posedge clk);
    hold_off = 1'b1;
    repeat (200) @(posedge clk);
    hold_off = 1'b0;
    wait (taken_beats >= 1100);
    @(posedge clk);
    hold_off = 1'b1;
    repeat (150) @(posedge clk);
    hold_off = 1'b0;
  end

  always @(posedge clk) begin : watchdog
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------- main
  initial begin : main
    int i;
    calm_left[SIDE_SEND] = 0;
    calm_left[SIDE_RECV] = 0;
    parser_clear();

    // byte, end flag, typed, then kind, byte, class, closes, ok when typed
    directed_tbl = '{
      {"a",     1'b0, 1'b1, KIND_NAME,     "a",   CLASS_PLAIN,   1'b0, 1'b0},
      {C_EQ,    1'b0, 1'b1, KIND_NAME_END, 8'h00, CLASS_PLAIN,   1'b0, 1'b0},
      {C_QUOTE, 1'b0, 1'b0, NO_RESULT},
      {8'h00,   1'b0, 1'b1, KIND_VALUE,    8'h00, CLASS_PLAIN,   1'b0, 1'b0},
      {8'hFF,   1'b0, 1'b1, KIND_VALUE,    8'hFF, CLASS_PLAIN,   1'b0, 1'b0},
      {C_QUOTE, 1'b0, 1'b0, NO_RESULT},
      {C_COMMA, 1'b0, 1'b0, NO_RESULT},
      {"b",     1'b0, 1'b0, NO_RESULT},
      {C_SP,    1'b0, 1'b1, KIND_NAME_END, 8'h00, CLASS_PLAIN,   1'b1, 1'b0},
      {C_EQ,    1'b0, 1'b0, NO_RESULT},
      {"v",     1'b0, 1'b0, NO_RESULT},
      {C_COMMA, 1'b0, 1'b0, NO_RESULT},
      {"x",     1'b0, 1'b0, NO_RESULT},
      {8'hFF,   1'b1, 1'b1, KIND_FINISH,   8'h00, CLASS_PLAIN,   1'b0, 1'b0},
      {"$",     1'b0, 1'b0, NO_RESULT},
      {"V",     1'b0, 1'b0, NO_RESULT},
      {"e",     1'b0, 1'b0, NO_RESULT},
      {"r",     1'b0, 1'b0, NO_RESULT},
      {"s",     1'b0, 1'b0, NO_RESULT},
      {"i",     1'b0, 1'b0, NO_RESULT},
      {"o",     1'b0, 1'b0, NO_RESULT},
      {"n",     1'b0, 1'b0, NO_RESULT},
      {C_EQ,    1'b0, 1'b1, KIND_NAME_END, 8'h00, CLASS_VERSION, 1'b0, 1'b0},
      {C_ONE,   1'b0, 1'b0, NO_RESULT},
      {C_SEMI,  1'b0, 1'b0, NO_RESULT},
      {8'h00,   1'b1, 1'b1, KIND_FINISH,   8'h00, CLASS_PLAIN,   1'b0, 1'b0}
    };
    for (i = 0; i < DIR_ROWS; i++) beat_q.push_back(directed_tbl[i]);

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (taken_beats < ITEM_TARGET) begin
      if (beat_q.size() < 64) gen_header();
      @(posedge clk);
    end
    while (beat_q.size() != 0 || result_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

[cookie_header_parser_top.f]
+incdir+rtl
rtl/chp_pkg.sv
rtl/chp_engine.sv
rtl/cookie_header_parser_top.sv
rtl/chp_checker.sv
sim/cookie_header_parser_top_tb.sv
